/* hdl/scd_pkg.sv */
`default_nettype none
package scd_pkg;

    // Field widths
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned PIXCNT_W   = 23;
    localparam int unsigned THRESH_W   = 8;
    localparam int unsigned FIRSTCHK_W = 16;
    localparam int unsigned INDEX_W    = 24;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned PIXSUM_W   = CHAN_W + 2;

    // Stream packing
    localparam int unsigned S_TDATA_W  = 3 * CHAN_W;
    localparam int unsigned M_TDATA_W  = INDEX_W + SUM_W;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = PIXCNT_W;

    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_COUNT     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CUT_THRESHOLD   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_CHECKED   = 2'd2;

    // Reset values
    localparam logic [PIXCNT_W-1:0]   PIXEL_COUNT_RST     = 23'd921600;
    localparam logic [THRESH_W-1:0]   CUT_THRESHOLD_RST   = 8'd30;
    localparam logic [FIRSTCHK_W-1:0] FIRST_CHECKED_RST   = 16'd5;

    // Default pixel limit per frame
    localparam int unsigned MAX_PIXELS_DEF = 4194304;

endpackage
`default_nettype wire

/* hdl/scd_limit.sv */
`default_nettype none
// Cut limit: (threshold + 1) * 3 * clamp(pixel_count, 1, MAX_PIXELS), two register stages.
module scd_limit
    import scd_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
    localparam int unsigned EFF_W     = $clog2(MAX_PIXELS + 1),
    localparam int unsigned PROD_W    = THRESH_W + 1 + EFF_W,
    localparam int unsigned LIM_W     = PROD_W + 2
) (
    input  wire logic                i_clk,
    input  wire logic [PIXCNT_W-1:0] i_pixel_count,
    input  wire logic [THRESH_W-1:0] i_cut_threshold,
    output logic      [LIM_W-1:0]    o_limit
);

    logic [EFF_W-1:0]    eff;
    logic [THRESH_W:0]   thr1;
    logic [PROD_W-1:0]   r_prod;
    logic [LIM_W-1:0]    r_limit;

    always_comb begin
        if (i_pixel_count == '0) begin
            eff = EFF_W'(1);
        end else if (32'(i_pixel_count) > 32'(MAX_PIXELS)) begin
            eff = EFF_W'(MAX_PIXELS);
        end else begin
            eff = EFF_W'(i_pixel_count);
        end
        thr1 = {1'b0, i_cut_threshold} + (THRESH_W+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= PROD_W'(thr1) * PROD_W'(eff);
        r_limit <= LIM_W'({r_prod, 1'b0}) + LIM_W'(r_prod);   // times three
    end

    assign o_limit = r_limit;

endmodule
`default_nettype wire

/* hdl/scene_cut_detector_unit.sv */
`default_nettype none
// Scene cut detector.
// Input stream: one BGR pixel per transaction, tdata = {red, green, blue}
// (blue in the low byte), tlast marks the last pixel of a frame.
// The channel values are summed into a saturating 32-bit frame sum. On each
// tlast pixel the frame sum is compared with the previous frame's sum; a cut
// is reported when |sum_now - sum_prev| >= (cut_threshold+1)*3*pixel_count
// and the frame index is at least first_checked_frame.
// Output stream: one transaction per frame, tdata = {frame_sum, frame_index},
// tuser = cut_found.
// Configuration: write channel with register index and data, always ready;
// index 0 pixel_count, 1 cut_threshold, 2 first_checked_frame, 3 ignored.
// Throughput: one pixel per cycle unless a stalled receiver holds the flow. The
// frame result of the tlast pixel reaches o_m_tvalid through three register
// stages (input, accumulate, compare/output). A stalled receiver fills the three
// stages; tready upstream drops only when all are occupied. Reset (synchronous,
// active low) clears the pipeline, frame sum, previous sum and frame counter,
// and restores register defaults. After a write the cut limit is rebuilt in the
// scd_limit product and limit registers; the pipeline depth covers that, so a
// pixel taken on the cycle after a write sees the new values.
module scene_cut_detector_unit
    import scd_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
    localparam int unsigned EFF_W     = $clog2(MAX_PIXELS + 1),
    localparam int unsigned LIM_W     = THRESH_W + 3 + EFF_W,
    localparam int unsigned CMP_W     = (LIM_W > SUM_W) ? LIM_W : SUM_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // pixel input
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,   // [7:0] blue, [15:8] green, [23:16] red
    input  wire logic                  i_s_tlast,   // frame_end
    // frame result output
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [M_TDATA_W-1:0]  o_m_tdata,   // [23:0] frame_index, [55:24] frame_sum
    output logic                       o_m_tuser,   // [0] cut_found
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [PIXCNT_W-1:0]   r_pixel_count;
    logic [THRESH_W-1:0]   r_cut_threshold;
    logic [FIRSTCHK_W-1:0] r_first_checked;
    logic [LIM_W-1:0]      limit;

    // stage 1: input register, channel sum precomputed
    logic                  r_s1_valid;
    logic [PIXSUM_W-1:0]   r_s1_add;
    logic                  r_s1_last;

    // stage 2: accumulator, frame result candidate
    logic [SUM_W-1:0]      r_run;
    logic [INDEX_W-1:0]    r_frame_cnt;
    logic                  r_s2_valid;
    logic [SUM_W-1:0]      r_s2_sum;
    logic [INDEX_W-1:0]    r_s2_idx;
    logic                  r_s2_chk;

    // stage 3: compare against previous frame, output register
    logic [SUM_W-1:0]      r_prior;
    logic                  r_out_valid;
    logic [INDEX_W-1:0]    r_out_idx;
    logic [SUM_W-1:0]      r_out_sum;
    logic                  r_out_cut;

    logic                  out_free;
    logic                  s2_free;
    logic                  s1_free;
    logic                  s1_go;
    logic                  s2_go;
    logic [SUM_W:0]        acc_wide;
    logic [SUM_W-1:0]      n_run;
    logic [SUM_W-1:0]      diff;
    logic                  n_cut;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count   <= PIXEL_COUNT_RST;
            r_cut_threshold <= CUT_THRESHOLD_RST;
            r_first_checked <= FIRST_CHECKED_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_PIXEL_COUNT:   r_pixel_count   <= i_cfg_data;
                REG_CUT_THRESHOLD: r_cut_threshold <= i_cfg_data[THRESH_W-1:0];
                REG_FIRST_CHECKED: r_first_checked <= i_cfg_data[FIRSTCHK_W-1:0];
                default: ;   // unknown index, write dropped
            endcase
        end
    end

    scd_limit #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_limit (
        .i_clk           (i_clk),
        .i_pixel_count   (r_pixel_count),
        .i_cut_threshold (r_cut_threshold),
        .o_limit         (limit)
    );

    // pipeline flow: a stage moves when the one after it is free or draining
    assign out_free   = !r_out_valid || i_m_tready;
    assign s2_free    = !r_s2_valid || out_free;
    assign s2_go      = r_s2_valid && out_free;
    assign s1_go      = r_s1_valid && s2_free;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_s_tready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_s_tvalid) begin
            r_s1_add  <= PIXSUM_W'(i_s_tdata[CHAN_W-1:0])
                       + PIXSUM_W'(i_s_tdata[2*CHAN_W-1:CHAN_W])
                       + PIXSUM_W'(i_s_tdata[3*CHAN_W-1:2*CHAN_W]);
            r_s1_last <= i_s_tlast;
        end
    end

    // saturating accumulate
    always_comb begin
        acc_wide = {1'b0, r_run} + (SUM_W+1)'(r_s1_add);
        n_run    = acc_wide[SUM_W] ? {SUM_W{1'b1}} : acc_wide[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_frame_cnt <= '0;
            r_s2_valid  <= 1'b0;
        end else begin
            if (s1_go) begin
                if (r_s1_last) begin
                    r_run       <= '0;
                    r_frame_cnt <= r_frame_cnt + INDEX_W'(1);
                end else begin
                    r_run <= n_run;
                end
            end
            if (s1_go && r_s1_last) begin
                r_s2_valid <= 1'b1;
            end else if (s2_go) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_s2_sum <= n_run;
            r_s2_idx <= r_frame_cnt;
            r_s2_chk <= (r_frame_cnt >= INDEX_W'(r_first_checked));
        end
    end

    // frame compare
    always_comb begin
        diff  = (r_s2_sum >= r_prior) ? (r_s2_sum - r_prior) : (r_prior - r_s2_sum);
        n_cut = r_s2_chk && (CMP_W'(diff) >= CMP_W'(limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_go) begin
                r_prior     <= r_s2_sum;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_out_idx <= r_s2_idx;
            r_out_sum <= r_s2_sum;
            r_out_cut <= n_cut;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_sum, r_out_idx};
    assign o_m_tuser  = r_out_cut;

endmodule
`default_nettype wire

/* hdl/scd_checker.sv */
`default_nettype none
module scd_checker
    import scd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  o_s_tready,
    input  wire logic                  i_s_tlast,
    input  wire logic                  o_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [M_TDATA_W-1:0]  o_m_tdata,
    input  wire logic                  o_m_tuser
);

    logic               in_last_acc;
    logic               out_acc;
    logic [2:0]         r_pending;
    logic               r_have_last;
    logic [INDEX_W-1:0] r_last_idx;

    assign in_last_acc = i_s_tvalid && o_s_tready && i_s_tlast;
    assign out_acc     = o_m_tvalid && i_m_tready;

    // frames ended but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_have_last <= 1'b0;
        end else begin
            r_pending <= r_pending + 3'(in_last_acc) - 3'(out_acc);
            if (out_acc) begin
                r_have_last <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_last_idx <= o_m_tdata[INDEX_W-1:0];
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_pending != 3'd0)
        else $error("frame result without an ended frame");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_have_last |-> o_m_tdata[INDEX_W-1:0] == r_last_idx + INDEX_W'(1))
        else $error("frame index not consecutive");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind scene_cut_detector_unit scd_checker u_scd_checker (.*);
`default_nettype wire

/* tb/tb_scene_cut_detector_unit.sv */
`timescale 1ns / 100ps
`default_nettype none

module tb_scene_cut_detector_unit;
    import scd_pkg::*;

    localparam int unsigned RESET_CYCLES     = 8;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    // pipeline is 3 deep; give it a few spare cycles before touching registers
    localparam int unsigned DRAIN_CYCLES     = 6;
    localparam int unsigned CFG_SETTLE       = 3;
    localparam int unsigned TAIL_CYCLES      = 10;
    localparam int unsigned RANDOM_PHASES    = 8;
    localparam int unsigned PIXELS_PER_PHASE = 100;
    localparam int unsigned MAX_IDLE         = 19;
    localparam int unsigned CHANNELS         = 3;
    // index 3 is decoded by nobody and must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              frame_end;
    } pixel_t;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [SUM_W-1:0]   sum;
        logic               cut;
    } frame_report_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tlast   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    scene_cut_detector_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Pixels waiting to go out, and frame reports the detector still owes us.
    pixel_t        pixel_backlog[$];
    frame_report_t pending_reports[$];

    // Shadow of the detector: frame accumulation state and register copies.
    logic [SUM_W-1:0]      acc_sum;
    logic [SUM_W-1:0]      last_frame_sum;
    logic [INDEX_W-1:0]    frames_seen;
    logic [PIXCNT_W-1:0]   cfg_pixels;
    logic [THRESH_W-1:0]   cfg_threshold;
    logic [FIRSTCHK_W-1:0] cfg_first_index;

    // Run bookkeeping
    bit          steady_flow = 1'b0;   // phase with no idling on either side
    int unsigned sender_wait;
    int unsigned receiver_wait;
    int unsigned cycle_count = 0;
    int unsigned failures = 0;
    int unsigned pixels_taken = 0;
    int unsigned frames_checked = 0;
    int unsigned cuts_seen = 0;
    int unsigned register_writes = 0;

    function automatic int unsigned draw_idle();
        return steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic pixel_t make_pixel(input int unsigned b, input int unsigned g,
                                          input int unsigned r, input bit last_px);
        pixel_t px;
        px.blue      = b[CHAN_W-1:0];
        px.green     = g[CHAN_W-1:0];
        px.red       = r[CHAN_W-1:0];
        px.frame_end = last_px;
        return px;
    endfunction

    // Register write as the detector sees it: fields are cut to their width,
    // unknown indices are dropped.
    function automatic void store_register(input logic [CFG_ADDR_W-1:0] addr,
                                           input logic [CFG_DATA_W-1:0] data);
        case (addr)
            REG_PIXEL_COUNT: begin
                cfg_pixels = data[PIXCNT_W-1:0];
            end
            REG_CUT_THRESHOLD: begin
                cfg_threshold = data[THRESH_W-1:0];
            end
            REG_FIRST_CHECKED: begin
                cfg_first_index = data[FIRSTCHK_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Add one pixel to the frame sum; on frame end predict the frame report.
    // The compare is the exact integer form of the truncated-average test:
    // |now - prev| >= (threshold + 1) * 3 * pixels.
    function automatic void absorb_pixel(input pixel_t px);
        logic [SUM_W+1:0]    total;
        logic [SUM_W-1:0]    delta;
        logic [63:0]         bound;
        logic [PIXCNT_W-1:0] divisor;
        frame_report_t       rep;
        total = {2'b00, acc_sum} + (SUM_W+2)'(px.blue) + (SUM_W+2)'(px.green)
              + (SUM_W+2)'(px.red);
        acc_sum = (total[SUM_W+1:SUM_W] != 2'b00) ? '1 : total[SUM_W-1:0];
        if (px.frame_end) begin
            delta = (acc_sum >= last_frame_sum) ? acc_sum - last_frame_sum
                                                : last_frame_sum - acc_sum;
            // zero count acts as one, oversized count is clamped
            if (cfg_pixels == '0)
                divisor = PIXCNT_W'(1);
            else if (32'(cfg_pixels) > MAX_PIXELS_DEF)
                divisor = PIXCNT_W'(MAX_PIXELS_DEF);
            else
                divisor = cfg_pixels;
            bound = (64'(cfg_threshold) + 64'd1) * 64'(CHANNELS) * 64'(divisor);
            rep.index = frames_seen;
            rep.sum   = acc_sum;
            rep.cut   = (frames_seen >= INDEX_W'(cfg_first_index)) && (64'(delta) >= bound);
            pending_reports.push_back(rep);
            last_frame_sum = acc_sum;
            acc_sum        = '0;
            frames_seen    = frames_seen + INDEX_W'(1);
        end
    endfunction

    // Input-side monitor: every accepted pixel and register write goes
    // through the shadow model in acceptance order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_sum         <= '0;
            last_frame_sum  <= '0;
            frames_seen     <= '0;
            cfg_pixels      <= PIXEL_COUNT_RST;
            cfg_threshold   <= CUT_THRESHOLD_RST;
            cfg_first_index <= FIRST_CHECKED_RST;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                absorb_pixel(make_pixel(i_s_tdata[CHAN_W-1:0], i_s_tdata[2*CHAN_W-1:CHAN_W],
                                        i_s_tdata[3*CHAN_W-1:2*CHAN_W], i_s_tlast));
                pixels_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                store_register(i_cfg_addr, i_cfg_data);
                register_writes++;
            end
        end
    end

    // Pixel driver: holds a transaction until it is taken, then waits its
    // drawn gap before launching the next one from the backlog.
    always @(posedge i_clk) begin
        pixel_t px;
        if (!i_rst_n) begin
            i_s_tvalid  <= 1'b0;
            sender_wait <= 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (sender_wait != 0) begin
                sender_wait <= sender_wait - 1;
                i_s_tvalid  <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
                px = pixel_backlog.pop_front();
                i_s_tdata   <= {px.red, px.green, px.blue};
                i_s_tlast   <= px.frame_end;
                i_s_tvalid  <= 1'b1;
                sender_wait <= draw_idle();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Report receiver and checker: stalls after each transaction for a
    // drawn number of cycles, compares each report with the oldest one owed.
    always @(posedge i_clk) begin
        int unsigned   hold;
        frame_report_t want;
        if (!i_rst_n) begin
            i_m_tready    <= 1'b0;
            receiver_wait <= 0;
        end else begin
            hold = receiver_wait;
            if (o_m_tvalid && i_m_tready) begin
                if (pending_reports.size() == 0) begin
                    $error("frame report with none owed: index %0d sum %0d cut %0b",
                           o_m_tdata[INDEX_W-1:0], o_m_tdata[INDEX_W+SUM_W-1:INDEX_W],
                           o_m_tuser);
                    failures++;
                end else begin
                    want = pending_reports.pop_front();
                    frames_checked++;
                    if (o_m_tuser)
                        cuts_seen++;
                    if (o_m_tdata[INDEX_W-1:0] !== want.index) begin
                        $error("frame_index: expected %0d, got %0d",
                               want.index, o_m_tdata[INDEX_W-1:0]);
                        failures++;
                    end
                    if (o_m_tdata[INDEX_W+SUM_W-1:INDEX_W] !== want.sum) begin
                        $error("frame_sum: expected %0d, got %0d",
                               want.sum, o_m_tdata[INDEX_W+SUM_W-1:INDEX_W]);
                        failures++;
                    end
                    if (o_m_tuser !== want.cut) begin
                        $error("cut_found: expected %0b, got %0b", want.cut, o_m_tuser);
                        failures++;
                    end
                end
                hold = draw_idle();
            end
            if (hold != 0) begin
                i_m_tready    <= 1'b0;
                receiver_wait <= hold - 1;
            end else begin
                i_m_tready    <= 1'b1;
                receiver_wait <= 0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports still owed",
                     cycle_count, pending_reports.size());
            $display("simulation failed");
            $finish;
        end
    end

    // One register write transaction; valid drops on the edge that takes it.
    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until the backlog is sent, the sender is idle and every owed report is in,
    // then the pipeline gets DRAIN_CYCLES to empty out trailing non-frame-end pixels.
    task automatic drain_pipeline();
        while (pixel_backlog.size() != 0 || i_s_tvalid || pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Whole frames with random content; each frame picks a brightness band
    // so consecutive frames often jump far enough to flag a cut.
    task automatic queue_frames(input int unsigned target);
        int unsigned queued;
        int unsigned frame_len;
        int unsigned band;
        int unsigned lo;
        int unsigned hi;
        queued = 0;
        while (queued < target) begin
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
            band = $urandom_range(0, 2);
            lo = (band == 1) ? 200 : 0;
            hi = (band == 0) ? 40 : 255;
            for (int unsigned k = 0; k < frame_len; k++)
                pixel_backlog.push_back(make_pixel($urandom_range(lo, hi),
                                                   $urandom_range(lo, hi),
                                                   $urandom_range(lo, hi),
                                                   k == frame_len - 1));
            queued += frame_len;
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_pixel_count(input int unsigned ph);
        if (ph % 4 != 3)
            return ($urandom_range(0, 5) == 0) ? CFG_DATA_W'(0)
                                               : CFG_DATA_W'($urandom_range(1, 4));
        case ($urandom_range(0, 3))
            0:       return CFG_DATA_W'(MAX_PIXELS_DEF);
            1:       return CFG_DATA_W'(MAX_PIXELS_DEF + 1);
            2:       return '1;
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_first_index();
        case ($urandom_range(0, 4))
            0:       return CFG_DATA_W'(0);
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(FIRSTCHK_W'(frames_seen + $urandom_range(0, 20)));
            3:       return CFG_DATA_W'(16'hFFFF);
            default: return CFG_DATA_W'($urandom_range(0, 300));
        endcase
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] thr;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero count (acts as one), zero threshold and frame 0
        // checkable, so frame 0 is judged against an empty prior sum.
        // The write to the unused index must change nothing.
        write_register(REG_PIXEL_COUNT, '0);
        write_register(REG_CUT_THRESHOLD, '0);
        write_register(REG_FIRST_CHECKED, '0);
        write_register(REG_UNUSED, '1);
        repeat (CFG_SETTLE) @(posedge i_clk);
        pixel_backlog.push_back(make_pixel(255, 255, 255, 1)); // 765 vs 0: cut
        pixel_backlog.push_back(make_pixel(0, 0, 0, 1));       // back to 0: cut
        pixel_backlog.push_back(make_pixel(0, 0, 0, 1));       // no change
        pixel_backlog.push_back(make_pixel(1, 1, 1, 1));       // diff equals limit: cut
        pixel_backlog.push_back(make_pixel(1, 1, 0, 1));       // diff 1: none
        pixel_backlog.push_back(make_pixel(255, 0, 0, 0));
        pixel_backlog.push_back(make_pixel(0, 255, 0, 0));
        pixel_backlog.push_back(make_pixel(0, 0, 255, 0));
        pixel_backlog.push_back(make_pixel(255, 255, 255, 1)); // four-pixel frame
        drain_pipeline();

        // Directed: oversized count (clamped), top threshold, last index
        // checkable; extra data bits above each field must be dropped.
        write_register(REG_PIXEL_COUNT, '1);
        write_register(REG_CUT_THRESHOLD, '1);
        write_register(REG_FIRST_CHECKED, '1);
        repeat (CFG_SETTLE) @(posedge i_clk);
        pixel_backlog.push_back(make_pixel(170, 85, 15, 0));
        pixel_backlog.push_back(make_pixel(85, 170, 240, 1));
        pixel_backlog.push_back(make_pixel(0, 0, 0, 1));
        pixel_backlog.push_back(make_pixel(255, 255, 255, 1));
        drain_pipeline();

        // Random phases, each with its own register setting.
        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
            steady_flow = (ph == 2) || (ph == 5);
            if (ph == 0)
                thr = '0;
            else if (ph == 1)
                thr = CFG_DATA_W'(8'hFF);
            else
                thr = CFG_DATA_W'($urandom_range(0, 255));
            // junk above the threshold field now and then
            if ($urandom_range(0, 3) == 0)
                thr[CFG_DATA_W-1:THRESH_W] = (CFG_DATA_W-THRESH_W)'($urandom());
            write_register(REG_PIXEL_COUNT, pick_pixel_count(ph));
            write_register(REG_CUT_THRESHOLD, thr);
            write_register(REG_FIRST_CHECKED, pick_first_index());
            if ($urandom_range(0, 3) == 0)
                write_register(REG_UNUSED, CFG_DATA_W'($urandom()));
            repeat (CFG_SETTLE) @(posedge i_clk);
            queue_frames(PIXELS_PER_PHASE);
            drain_pipeline();
        end
        steady_flow = 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("ran %0d pixels through %0d register writes; %0d frame reports checked, %0d cuts",
                 pixels_taken, register_writes, frames_checked, cuts_seen);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", failures);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* scene_cut_detector_unit.f */
hdl/scd_pkg.sv
hdl/scd_limit.sv
hdl/scene_cut_detector_unit.sv
hdl/scd_checker.sv
tb/tb_scene_cut_detector_unit.sv
